// ===== rtl/core/cde_pkg.sv =====
package cde_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam int unsigned OP_W = 3;
  localparam int unsigned KEY_W = 8;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_DUMP       = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WAIT
  } ctrl_state_e;

  typedef enum logic [1:0] {
    RD_FRONT,
    RD_BACK,
    RD_DUMP_NEXT
  } rd_sel_e;

  typedef enum logic [1:0] {
    SRC_MEM,
    SRC_EMPTY,
    SRC_FULL
  } out_src_e;

  typedef struct packed {
    logic     push_front;
    logic     push_back;
    logic     pop_front;
    logic     pop_back;
    logic     rd_en;
    rd_sel_e  rd_sel;
    logic     dump_clr;
    logic     dump_inc;
    logic     out_load;
    out_src_e out_src;
    logic     out_last;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic dump_last;
  } dp_sts_t;

endpackage

// ===== rtl/core/cde_if.sv =====
interface cde_in_if;
  import cde_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [KEY_W-1:0] key_in;

  modport source (output valid, output operation, output key_in, input ready);
  modport sink (input valid, input operation, input key_in, output ready);
endinterface

interface cde_out_if;
  import cde_pkg::*;

  logic                valid;
  logic                ready;
  logic [KEY_W-1:0]    key_out;
  logic [STATUS_W-1:0] status;
  logic                last;

  modport source (output valid, output key_out, output status, output last, input ready);
  modport sink (input valid, input key_out, input status, input last, output ready);
endinterface

// ===== rtl/core/cde_ctrl.sv =====
module cde_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [cde_pkg::OP_W-1:0] operation_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  cde_pkg::dp_sts_t      sts_i,
  output cde_pkg::dp_cmd_t      cmd_o
);
  import cde_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        dump_q, dump_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      dump_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      dump_q  <= dump_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    dump_d      = dump_q;
    cmd_o       = '0;
    cmd_o.rd_sel  = RD_FRONT;
    cmd_o.out_src = SRC_MEM;
    in_ready_o  = (state_q == ST_IDLE);
    out_valid_o = (state_q == ST_WAIT);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          dump_d = 1'b0;
          case (op_e'(operation_i))
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              if (sts_i.full) begin
                cmd_o.out_load = 1'b1;
                cmd_o.out_src  = SRC_FULL;
                cmd_o.out_last = 1'b1;
                state_d        = ST_WAIT;
              end else if (op_e'(operation_i) == OP_PUSH_FRONT) begin
                cmd_o.push_front = 1'b1;
              end else begin
                cmd_o.push_back = 1'b1;
              end
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              if (sts_i.empty) begin
                cmd_o.out_load = 1'b1;
                cmd_o.out_src  = SRC_EMPTY;
                cmd_o.out_last = 1'b1;
                state_d        = ST_WAIT;
              end else begin
                cmd_o.rd_en = 1'b1;
                if (op_e'(operation_i) == OP_POP_FRONT) begin
                  cmd_o.pop_front = 1'b1;
                  cmd_o.rd_sel    = RD_FRONT;
                end else begin
                  cmd_o.pop_back = 1'b1;
                  cmd_o.rd_sel   = RD_BACK;
                end
                state_d = ST_READ;
              end
            end
            OP_DUMP: begin
              if (sts_i.empty) begin
                cmd_o.out_load = 1'b1;
                cmd_o.out_src  = SRC_EMPTY;
                cmd_o.out_last = 1'b1;
                state_d        = ST_WAIT;
              end else begin
                cmd_o.rd_en    = 1'b1;
                cmd_o.rd_sel   = RD_FRONT;
                cmd_o.dump_clr = 1'b1;
                dump_d         = 1'b1;
                state_d        = ST_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        cmd_o.out_load = 1'b1;
        cmd_o.out_src  = SRC_MEM;
        cmd_o.out_last = dump_q ? sts_i.dump_last : 1'b1;
        state_d        = ST_WAIT;
      end
      ST_WAIT: begin
        if (out_ready_i) begin
          if (dump_q && !sts_i.dump_last) begin
            cmd_o.dump_inc = 1'b1;
            cmd_o.rd_en    = 1'b1;
            cmd_o.rd_sel   = RD_DUMP_NEXT;
            state_d        = ST_READ;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/cde_dp.sv =====
module cde_dp #(
  parameter int unsigned DEPTH = cde_pkg::DEPTH_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [cde_pkg::KEY_W-1:0]    key_in_i,
  input  cde_pkg::dp_cmd_t             cmd_i,
  output cde_pkg::dp_sts_t             sts_o,
  output logic [cde_pkg::KEY_W-1:0]    key_out_o,
  output logic [cde_pkg::STATUS_W-1:0] status_o,
  output logic                         last_o
);
  import cde_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_S = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  logic [KEY_W-1:0] mem [DEPTH];
  logic [KEY_W-1:0] rd_data_q;
  logic [AW-1:0]    front_q, front_d;
  logic [CW-1:0]    count_q, count_d;
  logic [AW-1:0]    idx_q, idx_d;
  logic [KEY_W-1:0] key_q;
  status_e          status_q;
  logic             last_q;
  logic [AW-1:0]    front_dec;
  logic [AW-1:0]    wr_addr;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] base, input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_S) begin
      sum = sum - DEPTH_S;
    end
    return sum[AW-1:0];
  endfunction

  assign front_dec = (front_q == '0) ? LAST_IDX : front_q - AW'(1);

  assign sts_o.empty     = (count_q == '0);
  assign sts_o.full      = (count_q == CW'(DEPTH));
  assign sts_o.dump_last = ((CW'(idx_q) + CW'(1)) == count_q);

  always_comb begin
    front_d = front_q;
    count_d = count_q;
    idx_d   = idx_q;
    wr_en   = 1'b0;
    wr_addr = front_dec;
    if (cmd_i.push_front) begin
      front_d = front_dec;
      count_d = count_q + CW'(1);
      wr_en   = 1'b1;
      wr_addr = front_dec;
    end else if (cmd_i.push_back) begin
      count_d = count_q + CW'(1);
      wr_en   = 1'b1;
      wr_addr = slot(front_q, count_q[AW-1:0]);
    end else if (cmd_i.pop_front) begin
      front_d = slot(front_q, AW'(1));
      count_d = count_q - CW'(1);
    end else if (cmd_i.pop_back) begin
      count_d = count_q - CW'(1);
    end
    if (cmd_i.dump_clr) begin
      idx_d = '0;
    end else if (cmd_i.dump_inc) begin
      idx_d = idx_q + AW'(1);
    end
  end

  always_comb begin
    case (cmd_i.rd_sel)
      RD_FRONT:     rd_addr = front_q;
      RD_BACK:      rd_addr = slot(front_q, AW'(count_q - CW'(1)));
      RD_DUMP_NEXT: rd_addr = slot(front_q, idx_q + AW'(1));
      default:      rd_addr = front_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  // key storage, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= key_in_i;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      last_q <= cmd_i.out_last;
      case (cmd_i.out_src)
        SRC_MEM: begin
          key_q    <= rd_data_q;
          status_q <= STATUS_OK;
        end
        SRC_EMPTY: begin
          key_q    <= '0;
          status_q <= STATUS_EMPTY;
        end
        SRC_FULL: begin
          key_q    <= '0;
          status_q <= STATUS_FULL;
        end
        default: begin
          key_q    <= '0;
          status_q <= STATUS_EMPTY;
        end
      endcase
    end
  end

  assign key_out_o = key_q;
  assign status_o  = status_q;
  assign last_o    = last_q;

endmodule

// ===== rtl/core/char_deque_engine.sv =====
// Double-ended queue of 8-bit keys in a circular buffer of DEPTH entries.
// One item is handled at a time. A push that fits gives no result; a push
// to a full queue, and a pop or dump of an empty queue, give one flagged
// result in the cycle after the item is taken. A pop gives its key, and a
// dump streams the stored keys front to back, last one marked, reading the
// next key only after the output has taken the one before: each key passes
// through the registered read port of the key memory and then the output
// register. The next item is taken in the cycle after the final result is
// taken.
module char_deque_engine #(
  parameter int unsigned DEPTH = cde_pkg::DEPTH_DEFAULT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cde_in_if.sink    in_i,
  cde_out_if.source out_o
);
  import cde_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  cde_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .operation_i (in_i.operation),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cde_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .key_in_i  (in_i.key_in),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .key_out_o (out_o.key_out),
    .status_o  (out_o.status),
    .last_o    (out_o.last)
  );

endmodule

// ===== verif/testbench.sv =====
module testbench;
  import cde_pkg::*;

  localparam int unsigned DEPTH = DEPTH_DEFAULT;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int RANDOM_ITEMS = 125;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 20;
  localparam int PLAN_ROWS = 13;
  localparam longint CYCLE_LIMIT = 500000;

  // codes the block ignores
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [STATUS_W-1:0] status;
    logic                last;
  } deque_result_t;

  typedef struct {
    logic [OP_W-1:0]     op;
    logic [KEY_W-1:0]    key;
    int                  reps;
    bit                  typed;
    logic [STATUS_W-1:0] typed_status;
  } plan_row_t;

  typedef enum {
    MODE_FILL,
    MODE_DRAIN,
    MODE_MIX
  } bias_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  cde_in_if  cmd_ch ();
  cde_out_if rsp_ch ();

  char_deque_engine #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_ch),
    .out_o (rsp_ch)
  );

  always #10 clk_i = ~clk_i;

  logic [KEY_W-1:0] shadow_keys [DEPTH];
  idx_t             shadow_front;
  cnt_t             shadow_count;

  deque_result_t awaited_results[$];
  deque_result_t step_results[$];
  plan_row_t     directed_plan [PLAN_ROWS];

  int     fail_count;
  int     checked_count;
  int     items_sent;
  int     dump_count;
  int     full_seen;
  int     empty_seen;
  bit     stall_request;
  bit     stall_done;
  longint cycle_count;

  function automatic deque_result_t make_result(logic [KEY_W-1:0] key,
                                                logic [STATUS_W-1:0] status, logic last);
    deque_result_t res;
    res.key = key;
    res.status = status;
    res.last = last;
    return res;
  endfunction

  function automatic idx_t slot_after(int offset);
    return idx_t'((int'(shadow_front) + offset) % DEPTH);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  task automatic predict_command(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
    step_results.delete();
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (shadow_count >= cnt_t'(DEPTH)) begin
          step_results.push_back(make_result('0, STATUS_FULL, 1'b1));
        end else begin
          if (op == OP_PUSH_FRONT) begin
            shadow_front = (shadow_front == '0) ? idx_t'(DEPTH - 1) : shadow_front - 1'b1;
            shadow_keys[shadow_front] = key;
          end else begin
            shadow_keys[slot_after(int'(shadow_count))] = key;
          end
          shadow_count = shadow_count + 1'b1;
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (shadow_count == '0) begin
          step_results.push_back(make_result('0, STATUS_EMPTY, 1'b1));
        end else if (op == OP_POP_FRONT) begin
          step_results.push_back(make_result(shadow_keys[shadow_front], STATUS_OK, 1'b1));
          shadow_front = slot_after(1);
          shadow_count = shadow_count - 1'b1;
        end else begin
          step_results.push_back(make_result(shadow_keys[slot_after(int'(shadow_count) - 1)],
                                             STATUS_OK, 1'b1));
          shadow_count = shadow_count - 1'b1;
        end
      end
      OP_DUMP: begin
        if (shadow_count == '0) begin
          step_results.push_back(make_result('0, STATUS_EMPTY, 1'b1));
        end else begin
          for (int i = 0; i < int'(shadow_count); i++) begin
            step_results.push_back(make_result(shadow_keys[slot_after(i)], STATUS_OK,
                                               (i + 1 == int'(shadow_count))));
          end
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_command(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                              input int gap, input bit typed,
                              input logic [STATUS_W-1:0] typed_status);
    @(negedge clk_i);
    cmd_ch.valid <= 1'b1;
    cmd_ch.operation <= op;
    cmd_ch.key_in <= key;
    @(posedge clk_i);
    while (!cmd_ch.ready) @(posedge clk_i);
    predict_command(op, key);
    if (typed) begin
      awaited_results.push_back(make_result('0, typed_status, 1'b1));
    end else begin
      foreach (step_results[i]) awaited_results.push_back(step_results[i]);
    end
    items_sent++;
    if (op == OP_DUMP) dump_count++;
    if (gap > 0) begin
      @(negedge clk_i);
      cmd_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    deque_result_t want;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected item: key_out %0h status %0d last %0b",
               rsp_ch.key_out, rsp_ch.status, rsp_ch.last);
        fail_count++;
      end else begin
        want = awaited_results.pop_front();
        checked_count++;
        if (want.status == STATUS_FULL) full_seen++;
        if (want.status == STATUS_EMPTY) empty_seen++;
        if (rsp_ch.key_out !== want.key) begin
          $error("key_out: expected %0h, actual %0h", want.key, rsp_ch.key_out);
          fail_count++;
        end
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
          fail_count++;
        end
        if (rsp_ch.last !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, rsp_ch.last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items still awaited", cycle_count,
               awaited_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver side, with one long hold-off on request
  initial begin : drive_ready
    int hi_left;
    int lo_left;
    int hold_count;
    hi_left = 0;
    lo_left = 0;
    hold_count = 0;
    rsp_ch.ready = 1'b0;
    while (!rst_ni) @(negedge clk_i);
    forever begin
      @(negedge clk_i);
      if (stall_request && !stall_done) begin
        rsp_ch.ready <= 1'b0;
        hold_count++;
        if (hold_count >= HOLD_CYCLES) stall_done = 1'b1;
      end else if (lo_left > 0) begin
        rsp_ch.ready <= 1'b0;
        lo_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (hi_left > 0) begin
          hi_left--;
        end else begin
          hi_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
          lo_left = pick_gap();
        end
      end
    end
  end

  initial begin : drive_commands
    bias_e           bias;
    int              seg_left;
    int              real_sent;
    int              gap;
    int              push_pct;
    int              r;
    bit              burst;
    logic [OP_W-1:0] op;
    logic [KEY_W-1:0] key;

    cmd_ch.valid = 1'b0;
    cmd_ch.operation = '0;
    cmd_ch.key_in = '0;

    directed_plan[0]  = '{OP_POP_FRONT,  8'h00, 1, 1'b1, STATUS_EMPTY};
    directed_plan[1]  = '{OP_POP_BACK,   8'hff, 1, 1'b1, STATUS_EMPTY};
    directed_plan[2]  = '{OP_DUMP,       8'h00, 1, 1'b1, STATUS_EMPTY};
    directed_plan[3]  = '{OP_SPARE_C,    8'hff, 1, 1'b0, STATUS_OK};
    directed_plan[4]  = '{OP_PUSH_FRONT, 8'h00, 1, 1'b0, STATUS_OK};
    directed_plan[5]  = '{OP_PUSH_BACK,  8'hff, 1, 1'b0, STATUS_OK};
    directed_plan[6]  = '{OP_PUSH_FRONT, 8'h80, 7, 1'b0, STATUS_OK};
    directed_plan[7]  = '{OP_PUSH_BACK,  8'h01, 7, 1'b0, STATUS_OK};
    directed_plan[8]  = '{OP_PUSH_FRONT, 8'h7f, 1, 1'b1, STATUS_FULL};
    directed_plan[9]  = '{OP_PUSH_BACK,  8'haa, 1, 1'b1, STATUS_FULL};
    directed_plan[10] = '{OP_DUMP,       8'h00, 1, 1'b0, STATUS_OK};
    directed_plan[11] = '{OP_POP_BACK,   8'h00, 1, 1'b0, STATUS_OK};
    directed_plan[12] = '{OP_POP_FRONT,  8'h00, 1, 1'b0, STATUS_OK};

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_plan[i]) begin
      for (int rep = 0; rep < directed_plan[i].reps; rep++) begin
        send_command(directed_plan[i].op, directed_plan[i].key + KEY_W'(rep), pick_gap(),
                     directed_plan[i].typed, directed_plan[i].typed_status);
      end
    end

    real_sent = 0;
    seg_left = 0;
    bias = MODE_MIX;
    burst = 1'b0;
    while (real_sent < RANDOM_ITEMS) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(5, 30);
        bias = bias_e'($urandom_range(0, 2));
        burst = ($urandom_range(0, 3) == 0);
      end
      seg_left--;
      if (real_sent == 60) stall_request = 1'b1;
      if (stall_request && !stall_done) bias = MODE_FILL;

      case (bias)
        MODE_FILL:  push_pct = 75;
        MODE_DRAIN: push_pct = 25;
        default:    push_pct = 50;
      endcase

      r = $urandom_range(0, 99);
      if (r < 3) begin
        case ($urandom_range(0, 2))
          0:       op = OP_SPARE_A;
          1:       op = OP_SPARE_B;
          default: op = OP_SPARE_C;
        endcase
      end else if (r < 11) begin
        op = OP_DUMP;
      end else if ($urandom_range(0, 99) < push_pct) begin
        op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      end else begin
        op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
      end

      if ($urandom_range(0, 9) == 0) key = $urandom_range(0, 1) ? 8'hff : 8'h00;
      else key = KEY_W'($urandom_range(0, 255));

      gap = (burst || (stall_request && !stall_done)) ? 0 : pick_gap();
      send_command(op, key, gap, 1'b0, STATUS_OK);
      if (op <= OP_DUMP) real_sent++;
    end

    @(negedge clk_i);
    cmd_ch.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (awaited_results.size() != 0) begin
      $error("%0d expected items never arrived", awaited_results.size());
      fail_count++;
    end

    $display("sent %0d commands (%0d dumps) from empty to full and back, %0d items checked",
             items_sent, dump_count, checked_count);
    $display("flagged items: %0d full, %0d empty; output held off %0d cycles once",
             full_seen, empty_seen, HOLD_CYCLES);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/cde_pkg.sv
rtl/core/cde_if.sv
rtl/core/cde_ctrl.sv
rtl/core/cde_dp.sv
rtl/core/char_deque_engine.sv
verif/testbench.sv
